@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL files; the tokenizer core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk once reset has been released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/exprtok_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package exprtok_pkg;

    localparam int TOKEN_VALUE_BITS = 32;

    typedef enum logic [3:0] {
        TK_END       = 4'd0,
        TK_PLUS      = 4'd1,
        TK_MINUS     = 4'd2,
        TK_MUL       = 4'd3,
        TK_DIV       = 4'd4,
        TK_OPEN      = 4'd5,
        TK_CLOSE     = 4'd6,
        TK_NUMBER    = 4'd7,
        TK_PRINT     = 4'd8,
        TK_PRINTLINE = 4'd9,
        TK_WORD      = 4'd10,
        TK_SEMI      = 4'd11,
        TK_ERROR     = 4'd12
    } token_kind_t;

    // Character codes.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    // Word lengths of the two keywords and the saturation point of the length count.
    localparam logic [3:0] KW_SHORT_LEN = 4'd5;
    localparam logic [3:0] KW_LONG_LEN  = 4'd9;
    localparam logic [3:0] WORD_LEN_MAX = 4'd15;

    typedef struct packed {
        token_kind_t                   kind;
        logic [TOKEN_VALUE_BITS-1:0]   value;
        logic                          sat;
        logic                          last;
    } token_t;

    // Up to two tokens produced by one character, in emission order.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } lex_out_t;

    // Letter expected at a given position of the longer keyword; zero past its end.
    function automatic logic [7:0] keyword_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h50; // P
            4'd1:    ch = 8'h52; // R
            4'd2:    ch = 8'h49; // I
            4'd3:    ch = 8'h4E; // N
            4'd4:    ch = 8'h54; // T
            4'd5:    ch = 8'h4C; // L
            4'd6:    ch = 8'h49; // I
            4'd7:    ch = 8'h4E; // N
            4'd8:    ch = 8'h45; // E
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic token_kind_t punct_kind(input logic [7:0] ch);
        token_kind_t kind;
        unique case (ch)
            CH_PLUS:  kind = TK_PLUS;
            CH_MINUS: kind = TK_MINUS;
            CH_STAR:  kind = TK_MUL;
            CH_SLASH: kind = TK_DIV;
            CH_OPEN:  kind = TK_OPEN;
            CH_CLOSE: kind = TK_CLOSE;
            CH_SEMI:  kind = TK_SEMI;
            default:  kind = TK_ERROR;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

@@ rtl/exprtok_char_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface exprtok_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

`default_nettype wire

@@ rtl/exprtok_token_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface exprtok_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] number_value;
    logic        saturated;
    logic        last_of_run;

    modport source (output valid, output token_kind, output number_value,
                    output saturated, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input number_value,
                    input saturated, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/expression_tokenizer_core.sv @@
// Channel   Direction  Payload                                         Accepted when
// chars     in         char_code[7:0], end_of_text                     valid && ready
// tokens    out        token_kind[3:0], number_value[31:0], saturated,  valid && ready
//                      last_of_run
//
// One character beat is taken per cycle while chars.ready is high, which is while at
// least two queue entries are free. Its tokens enter a four-entry token queue at the
// same edge, so the first token can show on tokens in the next cycle. The queue
// drains one token per cycle while tokens.ready is high; a character that closes a
// run and also gives its own token (punctuation, error or end) adds to the backlog.
// Reset is asynchronous and active low; it closes any open run and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module expression_tokenizer_core #(
    parameter int NUMBER_BITS = 32
) (
    input wire logic          clk,
    input wire logic          rst_n,
    exprtok_char_if.sink      chars,
    exprtok_token_if.source   tokens
);
    import exprtok_pkg::*;

    `include "assert_macros.svh"

    // The queue must hold the two tokens one character can produce.
    localparam int QueueDepth = 4;
    localparam int PtrBits    = $clog2(QueueDepth);
    localparam int FillBits   = PtrBits + 1;

    lex_out_t             lex_res;
    logic                 accept;
    logic                 pop;

    token_t               queue_reg [QueueDepth];
    logic [PtrBits-1:0]   wr_ptr_reg;
    logic [PtrBits-1:0]   rd_ptr_reg;
    logic [FillBits-1:0]  fill_reg;
    token_t               head;

    // A character beat is taken only when both of its possible tokens fit.
    assign chars.ready = (fill_reg <= FillBits'(QueueDepth - 2));
    assign accept      = chars.valid && chars.ready;
    assign pop         = tokens.valid && tokens.ready;

    exprtok_lexer #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .char_code   (chars.char_code),
        .end_of_text (chars.end_of_text),
        .result      (lex_res)
    );

    // Token storage: payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            if (lex_res.count != 2'd0) begin
                queue_reg[wr_ptr_reg] <= lex_res.first;
            end
            if (lex_res.count == 2'd2) begin
                queue_reg[wr_ptr_reg + PtrBits'(1)] <= lex_res.second;
            end
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= wr_ptr_reg + PtrBits'(lex_res.count);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PtrBits'(1);
            end
            fill_reg <= fill_reg + (accept ? FillBits'(lex_res.count) : '0)
                      - FillBits'(pop);
        end
    end

    assign head                = queue_reg[rd_ptr_reg];
    assign tokens.valid        = (fill_reg != '0);
    assign tokens.token_kind   = head.kind;
    assign tokens.number_value = head.value;
    assign tokens.saturated    = head.sat;
    assign tokens.last_of_run  = head.last;

    // The queue never holds more tokens than it has entries.
    `ASSERT_ALWAYS(a_fill_bound, fill_reg <= FillBits'(QueueDepth), "token queue overfilled")

    // An end-of-text beat always leaves at least its end token in the queue.
    `ASSERT_CLK(a_end_queued, accept && chars.end_of_text |=> fill_reg != '0, "end token lost")

    // The end token is always the final token of its character beat.
    `ASSERT_CLK(a_end_is_last, tokens.valid && head.kind == TK_END |-> head.last, "end not last")

endmodule

`default_nettype wire

@@ rtl/exprtok_lexer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module exprtok_lexer #(
    parameter int NUMBER_BITS = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [7:0]             char_code,
    input  wire logic                   end_of_text,
    output exprtok_pkg::lex_out_t       result
);
    import exprtok_pkg::*;

    localparam int AccBits   = NUMBER_BITS + 4;
    localparam int ValueBits = (NUMBER_BITS < TOKEN_VALUE_BITS) ? NUMBER_BITS
                                                                : TOKEN_VALUE_BITS;
    localparam logic [NUMBER_BITS-1:0] NumMax = {NUMBER_BITS{1'b1}};

    typedef enum logic [1:0] {
        RUN_NONE = 2'd0,
        RUN_NUM  = 2'd1,
        RUN_WORD = 2'd2
    } run_t;

    run_t                   run_reg, run_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic                   sat_reg, sat_next;
    logic [3:0]             len_reg, len_next;
    logic                   kw_ok_reg, kw_ok_next;

    logic                   is_digit, is_alpha, is_space;
    logic                   cont_num, cont_word, start_num, start_word;
    logic [NUMBER_BITS-1:0] base_acc;
    logic                   base_sat;
    logic [3:0]             base_len;
    logic                   base_ok;
    logic [AccBits-1:0]     times10;
    logic                   overflow;
    logic                   has_flush, has_other;
    token_t                 flush_tok, other_tok;
    token_kind_t            word_kind;

    always_comb
    begin
        is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_alpha = ((char_code >= CH_UP_A) && (char_code <= CH_UP_Z))
                || ((char_code >= CH_LO_A) && (char_code <= CH_LO_Z));
        is_space = (char_code == CH_SPACE) || (char_code == CH_TAB)
                || (char_code == CH_LF) || (char_code == CH_CR);

        cont_num   = !end_of_text && (run_reg == RUN_NUM) && is_digit;
        cont_word  = !end_of_text && (run_reg == RUN_WORD) && is_alpha;
        start_num  = !end_of_text && !cont_num && !cont_word && is_digit;
        start_word = !end_of_text && !cont_num && !cont_word && is_alpha;

        // A new run starts from the cleared state.
        base_acc = cont_num ? acc_reg : '0;
        base_sat = cont_num && sat_reg;
        base_len = cont_word ? len_reg : 4'd0;
        base_ok  = cont_word ? kw_ok_reg : 1'b1;

        // Ten times the value plus the digit; the low nibble of a digit is its value.
        times10  = (AccBits'(base_acc) << 3) + (AccBits'(base_acc) << 1)
                 + AccBits'(char_code[3:0]);
        overflow = base_sat || (times10 > AccBits'(NumMax));

        if (kw_ok_reg && (len_reg == KW_SHORT_LEN)) begin
            word_kind = TK_PRINT;
        end else if (kw_ok_reg && (len_reg == KW_LONG_LEN)) begin
            word_kind = TK_PRINTLINE;
        end else begin
            word_kind = TK_WORD;
        end

        flush_tok = '0;
        if (run_reg == RUN_NUM) begin
            flush_tok.kind  = TK_NUMBER;
            flush_tok.value = TOKEN_VALUE_BITS'(acc_reg[ValueBits-1:0]);
            flush_tok.sat   = sat_reg;
        end else begin
            flush_tok.kind  = word_kind;
        end

        other_tok      = '0;
        other_tok.kind = end_of_text ? TK_END : punct_kind(char_code);

        has_flush = !cont_num && !cont_word && (run_reg != RUN_NONE);
        has_other = end_of_text || (!is_space && !is_digit && !is_alpha);

        result = '0;
        if (has_flush && has_other) begin
            result.count       = 2'd2;
            result.first       = flush_tok;
            result.second      = other_tok;
            result.second.last = 1'b1;
        end else if (has_flush) begin
            result.count      = 2'd1;
            result.first      = flush_tok;
            result.first.last = 1'b1;
        end else if (has_other) begin
            result.count      = 2'd1;
            result.first      = other_tok;
            result.first.last = 1'b1;
        end

        run_next   = RUN_NONE;
        acc_next   = '0;
        sat_next   = 1'b0;
        len_next   = 4'd0;
        kw_ok_next = 1'b1;
        if (cont_num || start_num) begin
            run_next = RUN_NUM;
            acc_next = overflow ? NumMax : times10[NUMBER_BITS-1:0];
            sat_next = overflow;
        end else if (cont_word || start_word) begin
            run_next   = RUN_WORD;
            kw_ok_next = base_ok && (base_len < KW_LONG_LEN)
                      && (char_code == keyword_char(base_len));
            len_next   = (base_len == WORD_LEN_MAX) ? WORD_LEN_MAX : base_len + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg   <= RUN_NONE;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
            len_reg   <= 4'd0;
            kw_ok_reg <= 1'b1;
        end else if (step) begin
            run_reg   <= run_next;
            acc_reg   <= acc_next;
            sat_reg   <= sat_next;
            len_reg   <= len_next;
            kw_ok_reg <= kw_ok_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/expression_tokenizer_core_test.sv @@
`timescale 1ns / 1ps

module expression_tokenizer_core_test;

    import exprtok_pkg::*;

    // The watchdog ends the run after this many cycles in which no beat moves on
    // either channel. A correct run never comes near it: the token queue holds four
    // entries and both sides idle for only a few cycles at a time.
    localparam int STALL_LIMIT = 5000;
    // Minimum number of random character beats after the directed part.
    localparam int RANDOM_BEATS = 1050;
    // Cycles to wait after the last expected token, longer than a full token queue.
    localparam int SETTLE_CYCLES = 20;

    // Mirror of the tokenizer: it keeps its own copy of the open run and turns every
    // accepted character beat into the tokens the block must send, in order.
    class token_scoreboard;
        typedef enum logic [1:0] {
            RUN_IDLE,
            RUN_DIGITS,
            RUN_LETTERS
        } run_t;

        run_t        run;
        logic [31:0] accum;
        logic        clamped;
        logic [3:0]  letters;
        logic        kw_match;
        token_t      expected_q[$];
        int          errors;

        function new();
            errors = 0;
            clear_run();
        endfunction

        function void clear_run();
            run      = RUN_IDLE;
            accum    = '0;
            clamped  = 1'b0;
            letters  = '0;
            kw_match = 1'b1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_token(token_kind_t kind, logic [31:0] value, logic sat);
            token_t t;
            t.kind  = kind;
            t.value = value;
            t.sat   = sat;
            t.last  = 1'b0;
            expected_q.push_back(t);
        endfunction

        // Emits the token of the open run, if there is one, and closes the run.
        function int close_run();
            int n;
            n = 0;
            if (run == RUN_DIGITS) begin
                push_token(TK_NUMBER, accum, clamped);
                n = 1;
            end else if (run == RUN_LETTERS) begin
                if (kw_match && letters == KW_SHORT_LEN)
                    push_token(TK_PRINT, '0, 1'b0);
                else if (kw_match && letters == KW_LONG_LEN)
                    push_token(TK_PRINTLINE, '0, 1'b0);
                else
                    push_token(TK_WORD, '0, 1'b0);
                n = 1;
            end
            clear_run();
            return n;
        endfunction

        // Decimal accumulate; once the value would pass 2^32 - 1 it sticks there.
        function void take_digit(logic [7:0] c);
            longint unsigned top;
            longint unsigned wide;
            longint unsigned d;
            top  = 64'hFFFF_FFFF;
            wide = accum;
            d    = c - CH_ZERO;
            if (clamped || wide > (top - d) / 10) begin
                accum   = 32'hFFFF_FFFF;
                clamped = 1'b1;
            end else begin
                accum = 32'(wide * 10 + d);
            end
        endfunction

        // The word stays a keyword candidate only while it spells a prefix of the
        // longer keyword; the shorter one is its first five letters.
        function void take_letter(logic [7:0] c);
            string spelling;
            spelling = "PRINTLINE";
            if (letters >= KW_LONG_LEN || c != spelling[letters])
                kw_match = 1'b0;
            if (letters < WORD_LEN_MAX)
                letters++;
        endfunction

        function token_kind_t symbol_token(logic [7:0] c);
            case (c)
                CH_PLUS:  return TK_PLUS;
                CH_MINUS: return TK_MINUS;
                CH_STAR:  return TK_MUL;
                CH_SLASH: return TK_DIV;
                CH_OPEN:  return TK_OPEN;
                CH_CLOSE: return TK_CLOSE;
                CH_SEMI:  return TK_SEMI;
                default:  return TK_ERROR;
            endcase
        endfunction

        // Called for every accepted character beat.
        function void note_char(logic [7:0] c, logic eot);
            logic digit;
            logic alpha;
            logic blank;
            int   n;
            digit = c >= CH_ZERO && c <= CH_NINE;
            alpha = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
            blank = c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
            n = 0;
            if (eot) begin
                n = close_run();
                push_token(TK_END, '0, 1'b0);
                n++;
            end else if (run == RUN_DIGITS && digit) begin
                take_digit(c);
            end else if (run == RUN_LETTERS && alpha) begin
                take_letter(c);
            end else begin
                n = close_run();
                if (blank) begin
                    // Whitespace only ends a run.
                end else if (digit) begin
                    run = RUN_DIGITS;
                    take_digit(c);
                end else if (alpha) begin
                    run = RUN_LETTERS;
                    take_letter(c);
                end else begin
                    push_token(symbol_token(c), '0, 1'b0);
                    n++;
                end
            end
            if (n > 0)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%t ERROR: %s", $realtime, msg);
        endfunction

        // Called for every accepted token beat.
        function void check_token(logic [3:0] kind, logic [31:0] value, logic sat,
                                  logic last);
            token_t want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected token kind %0d value %0d sat %b last %b",
                               kind, value, sat, last));
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind || value !== want.value || sat !== want.sat ||
                last !== want.last)
                flag($sformatf({"token mismatch: expected kind %0d value %0d sat %b",
                                " last %b, got kind %0d value %0d sat %b last %b"},
                               want.kind, want.value, want.sat, want.last,
                               kind, value, sat, last));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    exprtok_char_if  chars_if ();
    exprtok_token_if tokens_if ();

    expression_tokenizer_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    token_scoreboard sb;

    // While calm is set neither side idles, which gives a long stretch at full rate.
    bit calm;
    int beats_sent;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Drives one character beat and returns at the edge where it is accepted. The
    // valid stays high afterwards so that beats can follow back to back;
    // an idle cycle lowers it at the start of the next call.
    task automatic send_char(input logic [7:0] c, input logic eot);
        while (!calm && $urandom_range(99) < 23)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid       <= 1'b1;
        chars_if.char_code   <= c;
        chars_if.end_of_text <= eot;
        do
            @(posedge clk);
        while (!chars_if.ready);
        sb.note_char(c, eot);
        beats_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    task automatic send_digits(input int count);
        for (int i = 0; i < count; i++)
            send_char(CH_ZERO + 8'($urandom_range(9)), 1'b0);
    endtask

    task automatic send_letters(input int count);
        for (int i = 0; i < count; i++)
            send_char(($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'($urandom_range(25)),
                      1'b0);
    endtask

    // Holds the character channel until every expected token has come out.
    task automatic drain_tokens();
        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    // One random piece of text. Most pieces are well-formed numbers, words and
    // operators so that runs open and close in every order; the rest is whitespace,
    // end markers and arbitrary bytes.
    task automatic send_random_lexeme();
        int         pick;
        logic [7:0] symbols[7];
        logic [7:0] blanks[4];
        symbols = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_OPEN, CH_CLOSE, CH_SEMI};
        blanks  = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
        pick    = $urandom_range(99);
        if (pick < 30)
        begin
            case ($urandom_range(9))
                0:       send_string("4294967295");      // largest value that fits
                1:       send_string("4294967296");      // one past it, so it clamps
                2:       send_digits($urandom_range(11, 16));
                default: send_digits($urandom_range(1, 6));
            endcase
        end
        else if (pick < 55)
        begin
            case ($urandom_range(9))
                0:       send_string("PRINT");
                1:       send_string("PRINTLINE");
                2:       send_string("print");           // keywords are case-sensitive
                3:       send_string("PRINTLIN");
                4:       send_string("PRINTLINES");
                5:       send_string("PRINTLINEPRINTLINE"); // length count saturates
                default: send_letters($urandom_range(1, 20));
            endcase
        end
        else if (pick < 72)
            send_char(symbols[$urandom_range(6)], 1'b0);
        else if (pick < 82)
            send_char(blanks[$urandom_range(3)], 1'b0);
        else if (pick < 87)
            send_char(8'($urandom), 1'b1);              // the byte must be ignored
        else
            send_char(8'($urandom_range(255)), 1'b0);
    endtask

    // Token side: the ready idles at random and every accepted token is checked.
    initial
    begin
        tokens_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            tokens_if.ready <= calm || ($urandom_range(99) >= 23);
            @(posedge clk);
            if (tokens_if.valid && tokens_if.ready)
                sb.check_token(tokens_if.token_kind, tokens_if.number_value,
                               tokens_if.saturated, tokens_if.last_of_run);
        end
    end

    // Watchdog: ends the run if no beat moves on either channel for too long.
    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((chars_if.valid && chars_if.ready) || (tokens_if.valid && tokens_if.ready))
                stall = 0;
            else
                stall++;
        end
        $display("%t timeout: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int  start;
        bit  paused;
        sb         = new();
        calm       = 1'b0;
        paused     = 1'b0;
        beats_sent = 0;
        rst_n                <= 1'b0;
        chars_if.valid       <= 1'b0;
        chars_if.char_code   <= '0;
        chars_if.end_of_text <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. End markers with no open run, one after another, and with
        // the all-ones byte on the ignored character field.
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        // A keyword closed by an operator, and a number closed by another: both
        // give two tokens from one beat.
        send_string("PRINT(7)");
        send_char(CH_TAB, 1'b0);
        send_string("+-*/ ;");
        send_char(CH_LF, 1'b0);
        send_char(CH_CR, 1'b0);
        // A two-letter word closed by an unknown byte, then a lone unknown byte.
        send_string("zA");
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        // A number still open when the end marker comes is flushed ahead of it.
        send_string("0");
        send_char(8'hFF, 1'b1);
        drain_tokens();

        // Random part, with one calm stretch and one full drain in the middle.
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS)
        begin
            calm = (beats_sent - start >= 300) && (beats_sent - start < 600);
            if (!paused && beats_sent - start >= 700)
            begin
                drain_tokens();
                paused = 1'b1;
            end
            send_random_lexeme();
        end
        // Close whatever run is still open so that its token is checked too.
        send_char(8'h00, 1'b1);
        calm = 1'b0;
        chars_if.valid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/exprtok_pkg.sv
rtl/exprtok_char_if.sv
rtl/exprtok_token_if.sv
rtl/exprtok_lexer.sv
rtl/expression_tokenizer_core.sv
tb/expression_tokenizer_core_test.sv
